FILE: design/kmc_pkg.sv
// shared types and constants for the interleaved k-mer comparator
`default_nettype none

package kmc_pkg;

	localparam int MAX_NUC = 32;
	localparam int NUC_W   = 2;
	localparam int SEQ_W   = MAX_NUC * NUC_W;
	localparam int LEN_W   = 6;
	localparam int POS_W   = $clog2(MAX_NUC);
	localparam int IN_W    = 2 * SEQ_W + LEN_W;
	localparam int IN_TW   = ((IN_W + 7) / 8) * 8;
	localparam int ORD_W   = 2;
	localparam int OUT_TW  = 8;

	localparam logic [LEN_W-1:0] SEQ_LEN_RESET = LEN_W'(MAX_NUC);

	// order codes, two's complement
	localparam logic [ORD_W-1:0] ORDER_LESS    = 2'b11;
	localparam logic [ORD_W-1:0] ORDER_EQUAL   = 2'b00;
	localparam logic [ORD_W-1:0] ORDER_GREATER = 2'b01;

	// per-nucleotide difference and greater-than flags, bit p is pair p from lsb
	typedef struct packed {
		logic [MAX_NUC-1:0] diff;
		logic [MAX_NUC-1:0] gt;
		logic [LEN_W-1:0]   suf_len;
	} kmc_mask_t;

	// nearest differences on both sides of the split
	typedef struct packed {
		logic               pre_found;
		logic [POS_W-1:0]   pre_pos;
		logic               suf_found;
		logic [POS_W-1:0]   suf_pos;
		logic [LEN_W-1:0]   suf_len;
		logic [MAX_NUC-1:0] gt;
	} kmc_loc_t;

endpackage

`default_nettype wire

FILE: design/kmc_diff.sv
// stage one: clamp length and split, build per-nucleotide difference masks
`default_nettype none

module kmc_diff
	import kmc_pkg::*;
(
	input  wire logic [SEQ_W-1:0] first_sequence,
	input  wire logic [SEQ_W-1:0] second_sequence,
	input  wire logic [LEN_W-1:0] split_position,
	input  wire logic [LEN_W-1:0] seq_len,
	output kmc_mask_t             mask
);

	logic [LEN_W-1:0] len_eff;
	logic [LEN_W-1:0] split_eff;

	always_comb begin
		len_eff   = (seq_len > LEN_W'(MAX_NUC)) ? LEN_W'(MAX_NUC) : seq_len;
		split_eff = (split_position > len_eff) ? len_eff : split_position;
		mask.suf_len = len_eff - split_eff;
		for (int p = 0; p < MAX_NUC; p++) begin
			mask.diff[p] = (LEN_W'(p) < len_eff) &&
				(first_sequence[NUC_W*p +: NUC_W] != second_sequence[NUC_W*p +: NUC_W]);
			mask.gt[p] = first_sequence[NUC_W*p +: NUC_W] > second_sequence[NUC_W*p +: NUC_W];
		end
	end

endmodule

`default_nettype wire

FILE: design/kmc_locate.sv
// stage two: nearest prefix and suffix differences around the split
`default_nettype none

module kmc_locate
	import kmc_pkg::*;
(
	input  wire kmc_mask_t mask,
	output kmc_loc_t       loc
);

	logic [MAX_NUC-1:0] low_mask;
	logic [MAX_NUC-1:0] pre_bits;
	logic [MAX_NUC-1:0] suf_bits;
	logic [MAX_NUC-1:0] suf_rev;
	logic [MAX_NUC-1:0] pre_iso;
	logic [MAX_NUC-1:0] suf_iso;
	logic [POS_W-1:0]   pre_idx;
	logic [POS_W-1:0]   rev_idx;

	always_comb begin
		for (int p = 0; p < MAX_NUC; p++) begin
			low_mask[p] = LEN_W'(p) < mask.suf_len;
		end
		// prefix sits above the suffix pairs, suffix in the low pairs
		pre_bits = mask.diff & ~low_mask;
		suf_bits = mask.diff & low_mask;
		for (int p = 0; p < MAX_NUC; p++) begin
			suf_rev[p] = suf_bits[MAX_NUC-1-p];
		end
		// lowest set bit of prefix, highest set bit of suffix
		pre_iso = pre_bits & (~pre_bits + MAX_NUC'(1));
		suf_iso = suf_rev & (~suf_rev + MAX_NUC'(1));
		pre_idx = '0;
		rev_idx = '0;
		for (int p = 0; p < MAX_NUC; p++) begin
			pre_idx = pre_idx | ({POS_W{pre_iso[p]}} & POS_W'(p));
			rev_idx = rev_idx | ({POS_W{suf_iso[p]}} & POS_W'(p));
		end
		loc.pre_found = |pre_bits;
		loc.pre_pos   = pre_idx;
		loc.suf_found = |suf_bits;
		loc.suf_pos   = POS_W'(MAX_NUC - 1) - rev_idx;
		loc.suf_len   = mask.suf_len;
		loc.gt        = mask.gt;
	end

endmodule

`default_nettype wire

FILE: design/kmc_decide.sv
// stage three: pick the nearer difference and turn it into an order code
`default_nettype none

module kmc_decide
	import kmc_pkg::*;
(
	input  wire kmc_loc_t    loc,
	output logic [ORD_W-1:0] order
);

	logic [LEN_W-1:0] pre_dist;
	logic [LEN_W-1:0] suf_dist;
	logic             use_pre;
	logic [POS_W-1:0] pos;

	always_comb begin
		pre_dist = {1'b0, loc.pre_pos} - loc.suf_len;
		suf_dist = loc.suf_len - LEN_W'(1) - {1'b0, loc.suf_pos};
		use_pre  = loc.pre_found && (!loc.suf_found || (pre_dist < suf_dist));
		pos      = use_pre ? loc.pre_pos : loc.suf_pos;
		if (!loc.pre_found && !loc.suf_found) begin
			order = ORDER_EQUAL;
		end else if (loc.gt[pos]) begin
			order = ORDER_GREATER;
		end else begin
			order = ORDER_LESS;
		end
	end

endmodule

`default_nettype wire

FILE: design/interleaved_kmer_compare.sv
// top level of the interleaved k-mer comparator
// pipeline: an accepted request is registered in mask_s1, then loc_s2, then order_s3, which drives m_tdata
// throughput: one request per cycle while the output is not stalled, set by three register stages sharing one stall
// a stalled output freezes the whole pipeline, so s_tready follows m_tready while m_tvalid is high
// reset: arst_n clears all valid bits and sets the sequence length to 32
`default_nettype none

module interleaved_kmer_compare
	import kmc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration: sequence length in nucleotides
	input  wire logic              cfg_wen,
	input  wire logic [LEN_W-1:0]  cfg_wdata,
	// request side
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// first_sequence[63:0], second_sequence[127:64], split_position[133:128], zero pad
	input  wire logic [IN_TW-1:0]  s_tdata,
	// result side
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// order[1:0], zero pad
	output logic [OUT_TW-1:0]      m_tdata
);

	// configured length, clamped later in stage one
	logic [LEN_W-1:0] seq_len_q;

	// pipeline advances whenever the output register can take a new value
	logic advance;

	logic             valid_s1, valid_s2, valid_s3;
	kmc_mask_t        mask_d, mask_s1;
	kmc_loc_t         loc_d, loc_s2;
	logic [ORD_W-1:0] order_d, order_s3;

	assign advance  = !valid_s3 || m_tready;
	assign s_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q <= SEQ_LEN_RESET;
		end else if (cfg_wen) begin
			seq_len_q <= cfg_wdata;
		end
	end

	// stage one: difference masks from the raw request
	kmc_diff u_diff (
		.first_sequence  (s_tdata[SEQ_W-1:0]),
		.second_sequence (s_tdata[2*SEQ_W-1:SEQ_W]),
		.split_position  (s_tdata[IN_W-1:2*SEQ_W]),
		.seq_len         (seq_len_q),
		.mask            (mask_d)
	);

	// stage two: nearest differences on each side of the split
	kmc_locate u_locate (
		.mask (mask_s1),
		.loc  (loc_d)
	);

	// stage three: final order code
	kmc_decide u_decide (
		.loc   (loc_s2),
		.order (order_d)
	);

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (advance) begin
			mask_s1  <= mask_d;
			loc_s2   <= loc_d;
			order_s3 <= order_d;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = {{(OUT_TW-ORD_W){1'b0}}, order_s3};

endmodule

`default_nettype wire

FILE: design/kmc_checker.sv
// port-level checker for the interleaved k-mer comparator, bound to the top level
`default_nettype none

module kmc_checker
	import kmc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              s_tready,
	input  wire logic              m_tvalid,
	input  wire logic              m_tready,
	input  wire logic [OUT_TW-1:0] m_tdata
);

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// only the three order codes, upper bits zero
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == {{(OUT_TW-ORD_W){1'b0}}, ORDER_LESS}) ||
			(m_tdata == {{(OUT_TW-ORD_W){1'b0}}, ORDER_EQUAL}) ||
			(m_tdata == {{(OUT_TW-ORD_W){1'b0}}, ORDER_GREATER}))
		else $error("illegal order code");

	// an accepted request with the output side ready while it moves through the stages has its result waiting
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
		else $error("result missing after request");

	// the input side only stalls when the output side does
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready out of step with output");

endmodule

bind interleaved_kmer_compare kmc_checker u_kmc_checker (.*);

`default_nettype wire
